// ----- hw/rtl/lrsc_pkg.sv -----
package lrsc_pkg;

   // Packet store and display geometry
   localparam int PACKET_DEPTH = 4;
   localparam int PACKET_INDEX_WIDTH = $clog2(PACKET_DEPTH);
   localparam int ROW_COUNT = 3;
   localparam int ROW_INDEX_WIDTH = 2;
   localparam int COLUMN_WIDTH = 7;
   localparam int MODE_WIDTH = 3;
   localparam int BYTE_WIDTH = 8;
   localparam int TICK_WIDTH = 8;
   localparam int PHASE_WIDTH = 4;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 8;

   // Row index that marks no active row
   localparam logic [ROW_INDEX_WIDTH-1:0] ROW_NONE = 2'd3;

   // Display mode codes; the remaining codes hold the drive state
   localparam logic [MODE_WIDTH-1:0] MODE_STEADY = 3'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_BLINK  = 3'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_FLASH  = 3'd2;

   // Register reset values
   localparam logic [BYTE_WIDTH-1:0]  NODE_ADDRESS_RESET = 8'd0;
   localparam logic [TICK_WIDTH-1:0]  BLINK_LIMIT_RESET  = 8'd36;
   localparam logic [TICK_WIDTH-1:0]  FLASH_LIMIT_RESET  = 8'd6;
   localparam logic [PHASE_WIDTH-1:0] FLASH_PHASES_RESET = 4'd5;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_NODE_ADDRESS = 2'd0,
      CSR_BLINK_LIMIT  = 2'd1,
      CSR_FLASH_LIMIT  = 2'd2,
      CSR_FLASH_PHASES = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                  mode;
      logic                  ninth_bit;
      logic [BYTE_WIDTH-1:0] rx_byte;
      logic                  framing_error;
      logic                  overrun_error;
   } req_item_type;

   typedef struct packed {
      logic [ROW_COUNT-1:0]    row_select;
      logic [COLUMN_WIDTH-1:0] column_bits;
      logic                    pattern_updated;
      logic                    rx_dropped;
   } rsp_item_type;

   // New mode and row patterns taken from the packet store
   typedef struct packed {
      logic                                   valid;
      logic [MODE_WIDTH-1:0]                  mode;
      logic [ROW_COUNT-1:0][COLUMN_WIDTH-1:0] rows;
   } latch_type;

   // Scan timing settings
   typedef struct packed {
      logic [TICK_WIDTH-1:0]  blink_limit;
      logic [TICK_WIDTH-1:0]  flash_limit;
      logic [PHASE_WIDTH-1:0] flash_phases;
   } scan_cfg_type;

   // Drive state after a transaction
   typedef struct packed {
      logic [ROW_COUNT-1:0]    row_select;
      logic [COLUMN_WIDTH-1:0] column_bits;
   } scan_view_type;

endpackage

// ----- hw/rtl/lrsc_if.sv -----
interface lrsc_req_if;
   import lrsc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  mode;
   logic                  ninth_bit;
   logic [BYTE_WIDTH-1:0] rx_byte;
   logic                  framing_error;
   logic                  overrun_error;

   modport source (output valid, mode, ninth_bit, rx_byte, framing_error, overrun_error,
                   input ready);
   modport sink (input valid, mode, ninth_bit, rx_byte, framing_error, overrun_error,
                 output ready);
endinterface

interface lrsc_rsp_if;
   import lrsc_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [ROW_COUNT-1:0]    row_select;
   logic [COLUMN_WIDTH-1:0] column_bits;
   logic                    pattern_updated;
   logic                    rx_dropped;

   modport source (output valid, row_select, column_bits, pattern_updated, rx_dropped,
                   input ready);
   modport sink (input valid, row_select, column_bits, pattern_updated, rx_dropped,
                 output ready);
endinterface

interface lrsc_csr_if;
   import lrsc_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/addressed_led_row_scan_controller_core.sv -----
// Path: a request is held in the input register, then its response is
// written to the result register and becomes valid there.
// Throughput: one transaction per cycle unless the response side stalls;
// the state update between the two registers is combinational.
// Reset: synchronous, active high; clears the pipeline, the packet store,
// the display state and the registers to their defaults.
module addressed_led_row_scan_controller_core import lrsc_pkg::*; (
   input logic         clock,
   input logic         reset,
   lrsc_req_if.sink    req_if,
   lrsc_rsp_if.source  rsp_if,
   lrsc_csr_if.sink    csr_if
);

   logic                   in_valid_ff, in_valid_in;
   req_item_type           in_item_ff, in_item_in;
   logic                   out_valid_ff, out_valid_in;
   rsp_item_type           out_item_ff, out_item_in;
   logic [BYTE_WIDTH-1:0]  node_address_ff, node_address_in;
   scan_cfg_type           cfg_ff, cfg_in;
   logic                   advance;
   logic                   req_take;
   logic                   char_error;
   logic                   char_step;
   logic                   tick_step;
   latch_type              latch;
   scan_view_type          view_next;

   // Move the held request into the result register when there is room
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_take = req_if.valid && req_if.ready;
   assign req_if.ready = !in_valid_ff || advance;

   assign char_error = in_item_ff.framing_error || in_item_ff.overrun_error;
   assign char_step  = advance && !in_item_ff.mode && !char_error;
   assign tick_step  = advance && in_item_ff.mode;

   lrsc_rx_decoder u_rx_decoder (
      .clock        (clock),
      .reset        (reset),
      .char_step    (char_step),
      .ninth_bit    (in_item_ff.ninth_bit),
      .rx_byte      (in_item_ff.rx_byte),
      .node_address (node_address_ff),
      .latch        (latch)
   );

   lrsc_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .tick_step (tick_step),
      .latch     (latch),
      .cfg       (cfg_ff),
      .view_next (view_next)
   );

   // Input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in              = 1'b1;
         in_item_in.mode          = req_if.mode;
         in_item_in.ninth_bit     = req_if.ninth_bit;
         in_item_in.rx_byte       = req_if.rx_byte;
         in_item_in.framing_error = req_if.framing_error;
         in_item_in.overrun_error = req_if.overrun_error;
      end
   end

   // Result register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (out_valid_ff && rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in                = 1'b1;
         out_item_in.row_select      = view_next.row_select;
         out_item_in.column_bits     = view_next.column_bits;
         out_item_in.pattern_updated = latch.valid;
         out_item_in.rx_dropped      = !in_item_ff.mode && char_error;
      end
   end

   assign rsp_if.valid           = out_valid_ff;
   assign rsp_if.row_select      = out_item_ff.row_select;
   assign rsp_if.column_bits     = out_item_ff.column_bits;
   assign rsp_if.pattern_updated = out_item_ff.pattern_updated;
   assign rsp_if.rx_dropped      = out_item_ff.rx_dropped;

   // Register writes
   assign csr_if.ready = 1'b1;

   always_comb begin
      node_address_in = node_address_ff;
      cfg_in          = cfg_ff;
      if (csr_if.valid) begin
         case (csr_index_type'(csr_if.index))
            CSR_NODE_ADDRESS: node_address_in     = csr_if.data;
            CSR_BLINK_LIMIT:  cfg_in.blink_limit  = csr_if.data;
            CSR_FLASH_LIMIT:  cfg_in.flash_limit  = csr_if.data;
            CSR_FLASH_PHASES: cfg_in.flash_phases = csr_if.data[PHASE_WIDTH-1:0];
            default:          node_address_in     = node_address_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff         <= 1'b0;
         out_valid_ff        <= 1'b0;
         node_address_ff     <= NODE_ADDRESS_RESET;
         cfg_ff.blink_limit  <= BLINK_LIMIT_RESET;
         cfg_ff.flash_limit  <= FLASH_LIMIT_RESET;
         cfg_ff.flash_phases <= FLASH_PHASES_RESET;
      end else begin
         in_valid_ff     <= in_valid_in;
         out_valid_ff    <= out_valid_in;
         node_address_ff <= node_address_in;
         cfg_ff          <= cfg_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

endmodule

// ----- hw/rtl/lrsc_rx_decoder.sv -----
module lrsc_rx_decoder import lrsc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  char_step,
   input  logic                  ninth_bit,
   input  logic [BYTE_WIDTH-1:0] rx_byte,
   input  logic [BYTE_WIDTH-1:0] node_address,
   output latch_type             latch
);

   logic                                    listening_ff, listening_in;
   logic [PACKET_INDEX_WIDTH-1:0]           index_ff, index_in;
   logic [PACKET_DEPTH-1:0][BYTE_WIDTH-1:0] bytes_ff, bytes_in;
   logic                                    addr_match;
   logic                                    data_write;

   assign addr_match = (rx_byte == node_address);
   assign data_write = char_step && !ninth_bit && listening_ff;

   // Address detection and packet store bookkeeping
   always_comb begin
      listening_in = listening_ff;
      index_in     = index_ff;
      bytes_in     = bytes_ff;
      if (char_step && ninth_bit) begin
         if (addr_match) begin
            listening_in = 1'b1;
            index_in     = '0;
         end else if (listening_ff) begin
            listening_in = 1'b0;
         end
      end
      if (data_write) begin
         bytes_in[index_ff] = rx_byte;
         if (index_ff == PACKET_INDEX_WIDTH'(PACKET_DEPTH - 1)) begin
            index_in = '0;
         end else begin
            index_in = index_ff + 1'b1;
         end
      end
   end

   // Unpack mode and row patterns from the first three bytes
   always_comb begin
      latch.valid   = char_step && ninth_bit && !addr_match && listening_ff;
      latch.mode    = bytes_ff[0][7:5];
      latch.rows[0] = {bytes_ff[0][4:0], bytes_ff[1][7:6]};
      latch.rows[1] = {bytes_ff[1][5:0], bytes_ff[2][7]};
      latch.rows[2] = bytes_ff[2][6:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         listening_ff <= 1'b0;
         index_ff     <= '0;
         bytes_ff     <= '0;
      end else begin
         listening_ff <= listening_in;
         index_ff     <= index_in;
         bytes_ff     <= bytes_in;
      end
   end

endmodule

// ----- hw/rtl/lrsc_scan.sv -----
module lrsc_scan import lrsc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          tick_step,
   input  latch_type     latch,
   input  scan_cfg_type  cfg,
   output scan_view_type view_next
);

   logic [MODE_WIDTH-1:0]                  mode_ff, mode_in;
   logic [ROW_COUNT-1:0][COLUMN_WIDTH-1:0] rows_ff, rows_in;
   logic [TICK_WIDTH-1:0]                  tick_ff, tick_in;
   logic [PHASE_WIDTH-1:0]                 phase_ff, phase_in;
   logic [ROW_INDEX_WIDTH-1:0]             row_ff, row_in;
   logic [COLUMN_WIDTH-1:0]                columns_ff, columns_in;
   logic [ROW_INDEX_WIDTH-1:0]             row_next;
   logic                                   advance_row;
   logic                                   blank;

   // Scan order: row 0, 1, 2, then back to 0
   always_comb begin
      case (row_ff)
         2'd0:    row_next = 2'd1;
         2'd1:    row_next = 2'd2;
         default: row_next = 2'd0;
      endcase
   end

   // Tick handling per display mode, latch overrides
   always_comb begin
      mode_in     = mode_ff;
      rows_in     = rows_ff;
      tick_in     = tick_ff;
      phase_in    = phase_ff;
      advance_row = 1'b0;
      blank       = 1'b0;
      if (tick_step) begin
         case (mode_ff)
            MODE_STEADY: begin
               advance_row = 1'b1;
            end
            MODE_BLINK: begin
               advance_row = 1'b1;
               tick_in     = tick_ff + 1'b1;
               if (tick_ff >= cfg.blink_limit) begin
                  tick_in  = '0;
                  phase_in = (phase_ff == '0) ? PHASE_WIDTH'(1) : '0;
               end
               blank = (phase_in == '0);
            end
            MODE_FLASH: begin
               advance_row = 1'b1;
               if (phase_ff < cfg.flash_phases) begin
                  tick_in = tick_ff + 1'b1;
                  if (tick_ff >= cfg.flash_limit) begin
                     tick_in  = '0;
                     phase_in = phase_ff + 1'b1;
                  end
                  blank = !phase_in[0];
               end
            end
            default: begin
               advance_row = 1'b0;
            end
         endcase
      end
      if (latch.valid) begin
         mode_in  = latch.mode;
         rows_in  = latch.rows;
         tick_in  = '0;
         phase_in = '0;
      end
   end

   // Drive the next row or hold
   always_comb begin
      row_in     = row_ff;
      columns_in = columns_ff;
      if (advance_row) begin
         row_in     = row_next;
         columns_in = blank ? '0 : rows_ff[row_next];
      end
   end

   // Present the drive state after this transaction
   always_comb begin
      case (row_in)
         2'd0:    view_next.row_select = 3'b001;
         2'd1:    view_next.row_select = 3'b010;
         2'd2:    view_next.row_select = 3'b100;
         default: view_next.row_select = 3'b000;
      endcase
      view_next.column_bits = columns_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_STEADY;
         rows_ff    <= '0;
         tick_ff    <= '0;
         phase_ff   <= '0;
         row_ff     <= ROW_NONE;
         columns_ff <= '0;
      end else begin
         mode_ff    <= mode_in;
         rows_ff    <= rows_in;
         tick_ff    <= tick_in;
         phase_ff   <= phase_in;
         row_ff     <= row_in;
         columns_ff <= columns_in;
      end
   end

endmodule

// ----- verif/addressed_led_row_scan_controller_core_test.sv -----
module addressed_led_row_scan_controller_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import lrsc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 8;
   localparam bit ITEM_CHAR = 1'b0;
   localparam bit ITEM_TICK = 1'b1;
   localparam bit CHAR_DATA = 1'b0;
   localparam bit CHAR_ADDRESS = 1'b1;

   logic clock;
   logic reset;

   lrsc_req_if req_bus ();
   lrsc_rsp_if rsp_bus ();
   lrsc_csr_if csr_bus ();

   addressed_led_row_scan_controller_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   // Handshake pacing and run bookkeeping
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int rsp_hold_cycles = 0;
   int fail_count = 0;
   int cycle_count = 0;

   // Drive states still owed by the block, oldest first
   rsp_item_type drive_q[$];

   // Mirror of the settings registers
   logic [BYTE_WIDTH-1:0]  set_address = NODE_ADDRESS_RESET;
   logic [TICK_WIDTH-1:0]  set_blink_limit = BLINK_LIMIT_RESET;
   logic [TICK_WIDTH-1:0]  set_flash_limit = FLASH_LIMIT_RESET;
   logic [PHASE_WIDTH-1:0] set_flash_phases = FLASH_PHASES_RESET;

   // Mirror of the receive and display state
   bit                      listen_on = 1'b0;
   logic [BYTE_WIDTH-1:0]   store_bytes [PACKET_DEPTH] = '{default: '0};
   logic [PACKET_INDEX_WIDTH-1:0] store_ptr = '0;
   logic [MODE_WIDTH-1:0]   disp_mode = MODE_STEADY;
   logic [COLUMN_WIDTH-1:0] row_art [ROW_COUNT] = '{default: '0};
   logic [TICK_WIDTH-1:0]   tick_cnt = '0;
   logic [PHASE_WIDTH-1:0]  phase_cnt = '0;
   logic [ROW_INDEX_WIDTH-1:0] lit_row = ROW_NONE;
   logic [COLUMN_WIDTH-1:0] lit_cols = '0;

   // Step to the next row and drive its pattern, or blank it
   function automatic void light_next_row(input bit blank);
      logic [ROW_INDEX_WIDTH-1:0] next_row;
      if (lit_row == 2'd0) begin
         next_row = 2'd1;
      end else if (lit_row == 2'd1) begin
         next_row = 2'd2;
      end else begin
         next_row = 2'd0;
      end
      lit_row = next_row;
      lit_cols = blank ? '0 : row_art[next_row];
   endfunction

   // Advance the display state for one transaction and queue the drive state it shows
   function automatic void predict_drive(input req_item_type item);
      rsp_item_type drive;
      logic [TICK_WIDTH-1:0] prior_ticks;
      drive = '0;
      if (item.mode == ITEM_TICK) begin
         case (disp_mode)
            MODE_STEADY: begin
               light_next_row(1'b0);
            end
            MODE_BLINK: begin
               prior_ticks = tick_cnt;
               tick_cnt = prior_ticks + 8'd1;
               if (prior_ticks >= set_blink_limit) begin
                  tick_cnt = '0;
                  phase_cnt = (phase_cnt == '0) ? 4'd1 : 4'd0;
               end
               light_next_row(phase_cnt == '0);
            end
            MODE_FLASH: begin
               if (phase_cnt >= set_flash_phases) begin
                  light_next_row(1'b0);
               end else begin
                  prior_ticks = tick_cnt;
                  tick_cnt = prior_ticks + 8'd1;
                  if (prior_ticks >= set_flash_limit) begin
                     tick_cnt = '0;
                     phase_cnt = phase_cnt + 4'd1;
                  end
                  light_next_row(phase_cnt[0] == 1'b0);
               end
            end
            default: begin
            end
         endcase
      end else if (item.framing_error || item.overrun_error) begin
         drive.rx_dropped = 1'b1;
      end else if (item.ninth_bit == CHAR_ADDRESS) begin
         if (item.rx_byte == set_address) begin
            listen_on = 1'b1;
            store_ptr = '0;
         end else if (listen_on) begin
            // Foreign address closes the packet: latch mode and row patterns
            listen_on = 1'b0;
            disp_mode = store_bytes[0][7:5];
            row_art[0] = {store_bytes[0][4:0], store_bytes[1][7:6]};
            row_art[1] = {store_bytes[1][5:0], store_bytes[2][7]};
            row_art[2] = store_bytes[2][6:0];
            tick_cnt = '0;
            phase_cnt = '0;
            drive.pattern_updated = 1'b1;
         end
      end else if (listen_on) begin
         store_bytes[store_ptr] = item.rx_byte;
         if (store_ptr == PACKET_INDEX_WIDTH'(PACKET_DEPTH - 1)) begin
            store_ptr = '0;
         end else begin
            store_ptr = store_ptr + 1'b1;
         end
      end
      drive.row_select = (lit_row == ROW_NONE) ? '0 : 3'(1 << lit_row);
      drive.column_bits = lit_cols;
      drive_q.push_back(drive);
   endfunction

   // Clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("addressed_led_row_scan_controller_core_test NOT OK");
         $finish;
      end
   end

   // Response side: random stalls, or a counted hold-off when one is requested
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_bus.ready = 1'b0;
            rsp_hold_cycles--;
         end else begin
            rsp_bus.ready = ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // Compare each response transaction with the oldest owed drive state
   always @(posedge clock) begin : check_responses
      rsp_item_type want;
      rsp_item_type got;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got.row_select = rsp_bus.row_select;
         got.column_bits = rsp_bus.column_bits;
         got.pattern_updated = rsp_bus.pattern_updated;
         got.rx_dropped = rsp_bus.rx_dropped;
         if (drive_q.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, actual 0x%0h", $time, got);
            fail_count++;
         end else begin
            want = drive_q.pop_front();
            check_field("row_select", 8'(want.row_select), 8'(got.row_select));
            check_field("column_bits", 8'(want.column_bits), 8'(got.column_bits));
            check_field("pattern_updated", 8'(want.pattern_updated),
                        8'(got.pattern_updated));
            check_field("rx_dropped", 8'(want.rx_dropped), 8'(got.rx_dropped));
         end
      end
   end

   // Offer one request transaction and predict its response once accepted
   task automatic send_item(input req_item_type item);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.mode = item.mode;
      req_bus.ninth_bit = item.ninth_bit;
      req_bus.rx_byte = item.rx_byte;
      req_bus.framing_error = item.framing_error;
      req_bus.overrun_error = item.overrun_error;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predict_drive(item);
   endtask

   task automatic send_char(input bit ninth, input logic [7:0] value,
                            input bit framing, input bit overrun);
      req_item_type item;
      item.mode = ITEM_CHAR;
      item.ninth_bit = ninth;
      item.rx_byte = value;
      item.framing_error = framing;
      item.overrun_error = overrun;
      send_item(item);
   endtask

   // Ticks carry random junk in the unused fields
   task automatic send_ticks(input int count);
      req_item_type item;
      logic [31:0] junk;
      for (int i = 0; i < count; i++) begin
         junk = $urandom;
         item = junk[$bits(req_item_type)-1:0];
         item.mode = ITEM_TICK;
         send_item(item);
      end
   endtask

   // Select, load three bytes, then close with a foreign address
   task automatic send_packet(input logic [7:0] b0, input logic [7:0] b1,
                              input logic [7:0] b2);
      send_char(CHAR_ADDRESS, set_address, 1'b0, 1'b0);
      send_char(CHAR_DATA, b0, 1'b0, 1'b0);
      send_char(CHAR_DATA, b1, 1'b0, 1'b0);
      send_char(CHAR_DATA, b2, 1'b0, 1'b0);
      send_char(CHAR_ADDRESS, set_address ^ 8'h80, 1'b0, 1'b0);
   endtask

   // Drop valid and wait until every owed response has been accepted
   task automatic drain_results();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (drive_q.size() != 0) @(posedge clock);
   endtask

   // Write one settings register while the block is idle
   task automatic write_setting(input csr_index_type idx, input logic [7:0] value);
      drain_results();
      @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data = value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      case (idx)
         CSR_NODE_ADDRESS: set_address = value;
         CSR_BLINK_LIMIT:  set_blink_limit = value;
         CSR_FLASH_LIMIT:  set_flash_limit = value;
         CSR_FLASH_PHASES: set_flash_phases = value[PHASE_WIDTH-1:0];
         default: begin
         end
      endcase
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // Reset defaults, error drops, ignored characters, rewind and store wrap
   task automatic test_directed();
      req_idle_pct = 20;
      rsp_idle_pct = 20;
      send_ticks(1);
      send_char(CHAR_DATA, 8'hFF, 1'b1, 1'b0);
      send_char(CHAR_ADDRESS, 8'h00, 1'b0, 1'b1);
      send_char(CHAR_ADDRESS, 8'h00, 1'b1, 1'b1);
      // data and foreign address while not selected are ignored
      send_char(CHAR_DATA, 8'hFF, 1'b0, 1'b0);
      send_char(CHAR_ADDRESS, 8'h55, 1'b0, 1'b0);
      // select, then five bytes so the store wraps onto entry zero
      send_char(CHAR_ADDRESS, 8'h00, 1'b0, 1'b0);
      send_char(CHAR_DATA, 8'hFF, 1'b0, 1'b0);
      send_char(CHAR_DATA, 8'h00, 1'b0, 1'b0);
      send_char(CHAR_DATA, 8'hAA, 1'b0, 1'b0);
      send_char(CHAR_DATA, 8'h55, 1'b0, 1'b0);
      send_char(CHAR_DATA, 8'hE0, 1'b0, 1'b0);
      // reselect rewinds the store
      send_char(CHAR_ADDRESS, 8'h00, 1'b0, 1'b0);
      send_char(CHAR_DATA, 8'h1F, 1'b0, 1'b0);
      // errored characters while selected change nothing
      send_char(CHAR_ADDRESS, 8'hFF, 1'b1, 1'b0);
      send_char(CHAR_DATA, 8'h80, 1'b0, 1'b1);
      send_char(CHAR_ADDRESS, 8'hFF, 1'b0, 1'b0);
      send_ticks(4);
   endtask

   // Blink mode at a small, the largest and the smallest limit
   task automatic test_blink_mode();
      write_setting(CSR_BLINK_LIMIT, 8'd3);
      send_packet(8'h3F, 8'hFF, 8'hFF);
      send_ticks(20);
      write_setting(CSR_BLINK_LIMIT, 8'd255);
      send_ticks(12);
      write_setting(CSR_BLINK_LIMIT, 8'd0);
      send_ticks(8);
   endtask

   // Flash mode through its phases, and steady from the start
   task automatic test_flash_mode();
      write_setting(CSR_FLASH_LIMIT, 8'd0);
      write_setting(CSR_FLASH_PHASES, 8'd15);
      send_packet(8'h5A, 8'hC3, 8'h96);
      send_ticks(20);
      write_setting(CSR_FLASH_PHASES, 8'd0);
      send_packet(8'h4D, 8'h2E, 8'h71);
      send_ticks(6);
      write_setting(CSR_FLASH_LIMIT, 8'd255);
      write_setting(CSR_FLASH_PHASES, 8'd5);
      send_packet(8'h55, 8'hAA, 8'h55);
      send_ticks(10);
      write_setting(CSR_FLASH_LIMIT, 8'd2);
      write_setting(CSR_FLASH_PHASES, 8'd3);
      send_packet(8'h5F, 8'h0F, 8'hF0);
      send_ticks(16);
   endtask

   // Hold modes keep the row and columns; then back to steady
   task automatic test_hold_modes();
      for (int m = 3; m < 8; m++) begin
         send_packet({3'(m), 5'h15}, 8'h6C, 8'hB1);
         send_ticks(4);
      end
      send_packet(8'h1B, 8'hD2, 8'h4E);
      send_ticks(4);
   endtask

   // Node address at its extremes
   task automatic test_address_select();
      write_setting(CSR_NODE_ADDRESS, 8'hFF);
      send_char(CHAR_ADDRESS, 8'h00, 1'b0, 1'b0);
      send_packet(8'h0C, 8'hF3, 8'h3C);
      send_ticks(3);
      write_setting(CSR_NODE_ADDRESS, 8'h00);
      send_char(CHAR_ADDRESS, 8'hFF, 1'b0, 1'b0);
      send_packet(8'h12, 8'h34, 8'h56);
      send_ticks(3);
   endtask

   // Random settings, then mostly well-formed packets and tick bursts with some noise
   task automatic test_random_traffic(input int req_pct, input int rsp_pct,
                                      input int count);
      int sent;
      int n_data;
      int n_ticks;
      logic [7:0] value;
      logic [7:0] other;
      sent = 0;
      value = $urandom_range(2) == 0 ? 8'h00 : ($urandom_range(1) ? 8'hFF : 8'($urandom));
      write_setting(CSR_NODE_ADDRESS, value);
      write_setting(CSR_BLINK_LIMIT,
                    $urandom_range(9) == 0 ? 8'd255 : 8'($urandom_range(12)));
      write_setting(CSR_FLASH_LIMIT,
                    $urandom_range(9) == 0 ? 8'd255 : 8'($urandom_range(6)));
      write_setting(CSR_FLASH_PHASES, 8'($urandom_range(15)));
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      while (sent < count) begin
         if ($urandom_range(99) < 15) begin
            send_char(1'($urandom_range(1)), 8'($urandom), $urandom_range(3) == 0,
                      $urandom_range(3) == 0);
            sent++;
         end else begin
            n_data = $urandom_range(6);
            send_char(CHAR_ADDRESS, set_address, $urandom_range(19) == 0,
                      $urandom_range(19) == 0);
            for (int i = 0; i < n_data; i++) begin
               value = 8'($urandom);
               if (i == 0) begin
                  value[7:5] = ($urandom_range(3) == 0) ? 3'($urandom_range(7, 3))
                                                       : 3'($urandom_range(2));
               end
               send_char(CHAR_DATA, value, $urandom_range(19) == 0,
                         $urandom_range(19) == 0);
               if ($urandom_range(19) == 0) begin
                  send_char(CHAR_ADDRESS, set_address, 1'b0, 1'b0);
               end
            end
            other = 8'($urandom);
            while (other == set_address) other = 8'($urandom);
            send_char(CHAR_ADDRESS, other, 1'b0, 1'b0);
            n_ticks = ($urandom_range(9) == 0) ? $urandom_range(150, 60)
                                               : $urandom_range(40, 1);
            send_ticks(n_ticks);
            sent += 2 + n_data + n_ticks;
         end
      end
   endtask

   // Hold the response side off long enough to stall the request side
   task automatic test_backpressure();
      drain_results();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      send_packet(8'h07, 8'h9A, 8'hC5);
      rsp_hold_cycles = 300;
      send_ticks(40);
   endtask

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.mode = ITEM_CHAR;
      req_bus.ninth_bit = CHAR_DATA;
      req_bus.rx_byte = '0;
      req_bus.framing_error = 1'b0;
      req_bus.overrun_error = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_NODE_ADDRESS;
      csr_bus.data = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_blink_mode();
      test_flash_mode();
      test_hold_modes();
      test_address_select();
      test_random_traffic(8, 79, 420);
      test_random_traffic(79, 8, 420);
      test_random_traffic(0, 0, 420);
      test_backpressure();

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("addressed_led_row_scan_controller_core_test OK");
      end else begin
         $display("addressed_led_row_scan_controller_core_test NOT OK");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/lrsc_pkg.sv
hw/rtl/lrsc_if.sv
hw/rtl/lrsc_rx_decoder.sv
hw/rtl/lrsc_scan.sv
hw/rtl/addressed_led_row_scan_controller_core.sv
verif/addressed_led_row_scan_controller_core_test.sv
